### rtl/oams_pkg.sv
`default_nettype none

package oams_pkg;

  // Mode timeouts in milliseconds
  localparam logic [31:0] TurnTimeMs     = 32'd800;
  localparam logic [31:0] BypassTimeMs   = 32'd1500;
  localparam logic [31:0] RecoverTimeMs  = 32'd1000;
  localparam logic [31:0] SideHoldTimeMs = 32'd500;

  localparam logic signed [15:0] NominalSpeed = 16'sd300;

  // Q8 gains: 0.55 and 0.45
  localparam logic [22:0] GainBypassQ8  = 23'd141;
  localparam logic [22:0] GainRecoverQ8 = 23'd115;
  localparam logic [22:0] RoundHalfQ8   = 23'd128;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRONT_STOP  = 3'd0,
    CFG_FRONT_SLOW  = 3'd1,
    CFG_SIDE_BLOCK  = 3'd2,
    CFG_SIDE_CLEAR  = 3'd3,
    CFG_SLOW_SPEED  = 3'd4,
    CFG_ASSIST_YAW  = 3'd5,
    CFG_RAMP_SPEED  = 3'd6,
    CFG_RAMP_YAW    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ASSIST_NONE    = 3'd0,
    ASSIST_SLOW    = 3'd1,
    ASSIST_PIVOT   = 3'd2,
    ASSIST_BYPASS  = 3'd3,
    ASSIST_RECOVER = 3'd4,
    ASSIST_VEER    = 3'd5
  } assist_e;

  // Register reset values
  localparam logic [15:0] FrontStopRst = 16'd300;
  localparam logic [15:0] FrontSlowRst = 16'd800;
  localparam logic [15:0] SideBlockRst = 16'd250;
  localparam logic [15:0] SideClearRst = 16'd500;
  localparam logic [14:0] SlowSpeedRst = 15'd150;
  localparam logic [14:0] AssistYawRst = 15'd800;
  localparam logic [14:0] RampSpdRst   = 15'd30;
  localparam logic [14:0] RampYawRst   = 15'd100;

endpackage

`default_nettype wire

### rtl/obstacle_avoid_motion_shaper.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ------------------------------------
// in        input      in_valid_i / in_ready_o    now_ms, ranges, speed_in, yaw_rate_in
// out       output     out_valid_o / out_ready_i  speed_out, yaw_rate_out, assist_code,
//                                                 hold_release, hold_lock
// cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high. An item is held in the input register,
// then the mode logic and ramp compute its result into the output register.
// Reset clears the mode state, sets the ramp to nominal speed and loads register defaults.
// When the output is stalled, the input register holds its item and in_ready_o drops
// only once both stages are full.

module obstacle_avoid_motion_shaper (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [oams_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [oams_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [31:0]                     now_ms_i,
  input  wire logic [15:0]                     front_range_i,
  input  wire logic [15:0]                     left_range_i,
  input  wire logic [15:0]                     right_range_i,
  input  wire logic signed [15:0]              speed_in_i,
  input  wire logic signed [15:0]              yaw_rate_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [15:0]                   speed_out_o,
  output logic signed [15:0]                   yaw_rate_out_o,
  output logic [2:0]                           assist_code_o,
  output logic                                 hold_release_o,
  output logic                                 hold_lock_o
);

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_PIVOT   = 3'd1,
    MODE_BYPASS  = 3'd2,
    MODE_RECOVER = 3'd3,
    MODE_VEER    = 3'd4
  } mode_e;

  // Configuration registers
  logic [15:0] front_stop_q, front_slow_q, side_block_q, side_clear_q;
  logic [14:0] slow_speed_q, assist_yaw_q, ramp_spd_step_q, ramp_yaw_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_stop_q    <= oams_pkg::FrontStopRst;
      front_slow_q    <= oams_pkg::FrontSlowRst;
      side_block_q    <= oams_pkg::SideBlockRst;
      side_clear_q    <= oams_pkg::SideClearRst;
      slow_speed_q    <= oams_pkg::SlowSpeedRst;
      assist_yaw_q    <= oams_pkg::AssistYawRst;
      ramp_spd_step_q <= oams_pkg::RampSpdRst;
      ramp_yaw_step_q <= oams_pkg::RampYawRst;
    end else if (cfg_we_i) begin
      unique case (oams_pkg::cfg_idx_e'(cfg_idx_i))
        oams_pkg::CFG_FRONT_STOP: front_stop_q    <= cfg_data_i;
        oams_pkg::CFG_FRONT_SLOW: front_slow_q    <= cfg_data_i;
        oams_pkg::CFG_SIDE_BLOCK: side_block_q    <= cfg_data_i;
        oams_pkg::CFG_SIDE_CLEAR: side_clear_q    <= cfg_data_i;
        oams_pkg::CFG_SLOW_SPEED: slow_speed_q    <= cfg_data_i[14:0];
        oams_pkg::CFG_ASSIST_YAW: assist_yaw_q    <= cfg_data_i[14:0];
        oams_pkg::CFG_RAMP_SPEED: ramp_spd_step_q <= cfg_data_i[14:0];
        oams_pkg::CFG_RAMP_YAW:   ramp_yaw_step_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic               s1_valid_q;
  logic [31:0]        now_q;
  logic [15:0]        front_q, left_q, right_q;
  logic signed [15:0] spd_in_q, yaw_in_q;
  logic               s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q    <= now_ms_i;
      front_q  <= front_range_i;
      left_q   <= left_range_i;
      right_q  <= right_range_i;
      spd_in_q <= speed_in_i;
      yaw_in_q <= yaw_rate_in_i;
    end
  end

  // Mode state
  mode_e              mode_q, mode_d;
  logic               side_pos_q, side_pos_d;  // 1: turn right (+1), 0: left (-1)
  logic [31:0]        start_q, start_d;
  logic               held_q, held_d;
  logic signed [15:0] ramp_spd_q, ramp_spd_d;
  logic signed [15:0] ramp_yaw_q, ramp_yaw_d;
  logic               out_valid_q;
  logic signed [15:0] spd_out_q, yaw_out_q, spd_res, yaw_res;
  oams_pkg::assist_e  code_q, code;
  logic               rel_q, lock_q, rel, lock;

  logic               left_wall, right_wall;
  logic [31:0]        elapsed;
  logic [22:0]        byp_prod, rec_prod;
  logic signed [15:0] aw_pos, aw_neg, byp_pos, byp_neg, rec_pos, rec_neg, sv;
  logic signed [15:0] v, w;
  logic               assisted;
  logic signed [16:0] d_spd, d_yaw, c_spd, c_yaw, stp_spd, stp_yaw;
  logic signed [16:0] sum_spd, sum_yaw;

  assign left_wall  = (left_q < side_block_q) && (right_q > side_clear_q);
  assign right_wall = (right_q < side_block_q) && (left_q > side_clear_q);
  assign elapsed    = now_q - start_q;

  assign byp_prod = {8'd0, assist_yaw_q} * oams_pkg::GainBypassQ8 + oams_pkg::RoundHalfQ8;
  assign rec_prod = {8'd0, assist_yaw_q} * oams_pkg::GainRecoverQ8 + oams_pkg::RoundHalfQ8;

  assign aw_pos  = $signed({1'b0, assist_yaw_q});
  assign aw_neg  = -aw_pos;
  assign byp_pos = $signed({1'b0, byp_prod[22:8]});
  assign byp_neg = -byp_pos;
  assign rec_pos = $signed({1'b0, rec_prod[22:8]});
  assign rec_neg = -rec_pos;
  assign sv      = $signed({1'b0, slow_speed_q});

  always_comb begin
    mode_d     = mode_q;
    side_pos_d = side_pos_q;
    start_d    = start_q;
    held_d     = held_q;
    v          = spd_in_q;
    w          = yaw_in_q;
    code       = oams_pkg::ASSIST_NONE;
    assisted   = 1'b0;
    rel        = 1'b0;
    lock       = 1'b0;

    unique case (mode_q)
      MODE_NONE: begin
        if (front_q < front_stop_q) begin
          rel        = 1'b1;
          held_d     = 1'b1;
          side_pos_d = right_q > left_q;
          mode_d     = MODE_PIVOT;
          start_d    = now_q;
          v          = '0;
          w          = (right_q > left_q) ? aw_pos : aw_neg;
          code       = oams_pkg::ASSIST_PIVOT;
          assisted   = 1'b1;
        end else if (left_wall || right_wall) begin
          rel        = 1'b1;
          held_d     = 1'b1;
          side_pos_d = left_wall;
          mode_d     = MODE_VEER;
          start_d    = now_q;
          v          = sv;
          w          = left_wall ? aw_pos : aw_neg;
          code       = oams_pkg::ASSIST_VEER;
          assisted   = 1'b1;
        end else begin
          if (front_q < front_slow_q) begin
            // cap from above only
            if (spd_in_q > sv) v = sv;
            code     = oams_pkg::ASSIST_SLOW;
            assisted = 1'b1;
          end
          if (held_q) begin
            lock   = 1'b1;
            held_d = 1'b0;
          end
        end
      end
      MODE_PIVOT: begin
        rel      = 1'b1;
        held_d   = 1'b1;
        assisted = 1'b1;
        code     = oams_pkg::ASSIST_PIVOT;
        v        = '0;
        w        = side_pos_q ? aw_pos : aw_neg;
        if (elapsed >= oams_pkg::TurnTimeMs || front_q > front_slow_q) begin
          mode_d  = MODE_BYPASS;
          start_d = now_q;
        end
      end
      MODE_BYPASS: begin
        rel      = 1'b1;
        held_d   = 1'b1;
        assisted = 1'b1;
        code     = oams_pkg::ASSIST_BYPASS;
        v        = sv;
        w        = side_pos_q ? byp_pos : byp_neg;
        if (elapsed >= oams_pkg::BypassTimeMs || front_q < front_stop_q) begin
          mode_d  = MODE_RECOVER;
          start_d = now_q;
        end
      end
      MODE_RECOVER: begin
        rel      = 1'b1;
        held_d   = 1'b1;
        assisted = 1'b1;
        code     = oams_pkg::ASSIST_RECOVER;
        v        = sv;
        w        = side_pos_q ? rec_neg : rec_pos;
        if (elapsed >= oams_pkg::RecoverTimeMs) begin
          mode_d = MODE_NONE;
          lock   = 1'b1;
          held_d = 1'b0;
        end
      end
      MODE_VEER: begin
        rel      = 1'b1;
        held_d   = 1'b1;
        assisted = 1'b1;
        code     = oams_pkg::ASSIST_VEER;
        v        = sv;
        w        = side_pos_q ? aw_pos : aw_neg;
        // leave once the hold time is up and the wall that started the veer is gone
        if (elapsed >= oams_pkg::SideHoldTimeMs &&
            !(side_pos_q ? left_wall : right_wall)) begin
          mode_d = MODE_NONE;
          lock   = 1'b1;
          held_d = 1'b0;
        end
      end
      default: begin
        mode_d = MODE_NONE;
      end
    endcase
  end

  // Ramp: while assisted, step toward target by at most one step per item; else follow the target
  assign stp_spd = $signed({2'b00, ramp_spd_step_q});
  assign stp_yaw = $signed({2'b00, ramp_yaw_step_q});
  assign d_spd   = $signed({v[15], v}) - $signed({ramp_spd_q[15], ramp_spd_q});
  assign d_yaw   = $signed({w[15], w}) - $signed({ramp_yaw_q[15], ramp_yaw_q});

  always_comb begin
    if (d_spd > stp_spd)       c_spd = stp_spd;
    else if (d_spd < -stp_spd) c_spd = -stp_spd;
    else                       c_spd = d_spd;
    if (d_yaw > stp_yaw)       c_yaw = stp_yaw;
    else if (d_yaw < -stp_yaw) c_yaw = -stp_yaw;
    else                       c_yaw = d_yaw;
  end

  assign sum_spd = $signed({ramp_spd_q[15], ramp_spd_q}) + c_spd;
  assign sum_yaw = $signed({ramp_yaw_q[15], ramp_yaw_q}) + c_yaw;

  always_comb begin
    if (assisted) begin
      ramp_spd_d = sum_spd[15:0];
      ramp_yaw_d = sum_yaw[15:0];
    end else begin
      ramp_spd_d = v;
      ramp_yaw_d = w;
    end
    spd_res = ramp_spd_d;
    yaw_res = ramp_yaw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      side_pos_q  <= 1'b0;
      start_q     <= '0;
      held_q      <= 1'b0;
      ramp_spd_q  <= oams_pkg::NominalSpeed;
      ramp_yaw_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_q     <= mode_d;
        side_pos_q <= side_pos_d;
        start_q    <= start_d;
        held_q     <= held_d;
        ramp_spd_q <= ramp_spd_d;
        ramp_yaw_q <= ramp_yaw_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      spd_out_q <= spd_res;
      yaw_out_q <= yaw_res;
      code_q    <= code;
      rel_q     <= rel;
      lock_q    <= lock;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign speed_out_o    = spd_out_q;
  assign yaw_rate_out_o = yaw_out_q;
  assign assist_code_o  = code_q;
  assign hold_release_o = rel_q;
  assign hold_lock_o    = lock_q;

endmodule

`default_nettype wire

### dv/obstacle_avoid_motion_shaper_tb.sv
`timescale 1ns / 100ps

module obstacle_avoid_motion_shaper_tb;

  localparam logic [31:0] PivotMs    = 32'd800;
  localparam logic [31:0] BypassMs   = 32'd1500;
  localparam logic [31:0] RecoverMs  = 32'd1000;
  localparam logic [31:0] VeerHoldMs = 32'd500;
  localparam int NominalSpd     = 300;
  localparam int BypassGainQ8   = 141;
  localparam int RecoverGainQ8  = 115;
  localparam int IdlePct        = 38;
  localparam int DrainCycles    = 6;
  localparam int WatchdogLimit  = 2000;
  localparam int MaxPrinted     = 40;

  typedef enum logic [2:0] {
    MODE_NONE, MODE_PIVOT, MODE_BYPASS, MODE_RECOVER, MODE_VEER
  } avoid_mode_e;

  typedef enum int {TK_NEAR, TK_PIVOT, TK_WALL_L, TK_WALL_R, TK_NOISE} tick_kind_e;

  typedef struct packed {
    logic [31:0]        now;
    logic [15:0]        front;
    logic [15:0]        left;
    logic [15:0]        right;
    logic signed [15:0] spd;
    logic signed [15:0] yaw;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] spd;
    logic signed [15:0] yaw;
    oams_pkg::assist_e  code;
    logic               rel;
    logic               lock;
  } shaped_t;

  typedef struct packed {
    logic [15:0] front_stop;
    logic [15:0] front_slow;
    logic [15:0] side_block;
    logic [15:0] side_clear;
    logic [14:0] slow_speed;
    logic [14:0] assist_yaw;
    logic [14:0] spd_step;
    logic [14:0] yaw_step;
  } cfg_set_t;

  localparam cfg_set_t DefaultCfg = {16'd300, 16'd800, 16'd250, 16'd500,
                                     15'd150, 15'd800, 15'd30, 15'd100};

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  oams_pkg::cfg_idx_e cfg_idx;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready_o;
  logic [31:0]        now_ms;
  logic [15:0]        front_range;
  logic [15:0]        left_range;
  logic [15:0]        right_range;
  logic signed [15:0] speed_in;
  logic signed [15:0] yaw_rate_in;
  logic               out_valid_o;
  logic               out_ready;
  logic signed [15:0] speed_out_o;
  logic signed [15:0] yaw_rate_out_o;
  logic [2:0]         assist_code_o;
  logic               hold_release_o;
  logic               hold_lock_o;

  // shaper state as the predictor tracks it
  cfg_set_t    cfg;
  avoid_mode_e mdl_mode;
  int          mdl_side;
  logic [31:0] mdl_start;
  bit          mdl_released;
  int          ramp_spd;
  int          ramp_yaw;

  shaped_t     shaped_q[$];
  logic [31:0] t_ms;
  bit          no_idle;
  int          n_sent;
  int          n_checked;
  int          n_err;
  int          n_cfg_loads;
  int          n_locks;
  int          code_hits[6];

  obstacle_avoid_motion_shaper u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .now_ms_i       (now_ms),
    .front_range_i  (front_range),
    .left_range_i   (left_range),
    .right_range_i  (right_range),
    .speed_in_i     (speed_in),
    .yaw_rate_in_i  (yaw_rate_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .speed_out_o    (speed_out_o),
    .yaw_rate_out_o (yaw_rate_out_o),
    .assist_code_o  (assist_code_o),
    .hold_release_o (hold_release_o),
    .hold_lock_o    (hold_lock_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_delta(int d, int lim);
    if (d > lim) return lim;
    if (d < -lim) return -lim;
    return d;
  endfunction

  function automatic shaped_t shape_tick(tick_t t);
    shaped_t     r;
    int          v, w, aw, sv, f, l, rt;
    logic [31:0] elapsed;
    bit          assisted, left_wall, right_wall, keep;
    v = $signed(t.spd);
    w = $signed(t.yaw);
    aw = cfg.assist_yaw;
    sv = cfg.slow_speed;
    f = t.front;
    l = t.left;
    rt = t.right;
    r = '0;
    r.code = oams_pkg::ASSIST_NONE;
    assisted = 1'b0;
    left_wall = (l < cfg.side_block) && (rt > cfg.side_clear);
    right_wall = (rt < cfg.side_block) && (l > cfg.side_clear);
    elapsed = t.now - mdl_start;

    if (mdl_mode != MODE_NONE) begin
      assisted = 1'b1;
      r.rel = 1'b1;
      mdl_released = 1'b1;
      case (mdl_mode)
        MODE_PIVOT: begin
          r.code = oams_pkg::ASSIST_PIVOT;
          v = 0;
          w = mdl_side * aw;
          if (elapsed >= PivotMs || f > cfg.front_slow) begin
            mdl_mode = MODE_BYPASS;
            mdl_start = t.now;
          end
        end
        MODE_BYPASS: begin
          r.code = oams_pkg::ASSIST_BYPASS;
          v = sv;
          w = mdl_side * ((aw * BypassGainQ8 + 128) >> 8);
          if (elapsed >= BypassMs || f < cfg.front_stop) begin
            mdl_mode = MODE_RECOVER;
            mdl_start = t.now;
          end
        end
        MODE_RECOVER: begin
          r.code = oams_pkg::ASSIST_RECOVER;
          v = sv;
          w = -mdl_side * ((aw * RecoverGainQ8 + 128) >> 8);
          if (elapsed >= RecoverMs) begin
            mdl_mode = MODE_NONE;
            mdl_side = 0;
            r.lock = 1'b1;
            mdl_released = 1'b0;
          end
        end
        default: begin
          r.code = oams_pkg::ASSIST_VEER;
          v = sv;
          w = mdl_side * aw;
          // veer holds while its own wall is still there
          keep = (mdl_side > 0) ? left_wall : right_wall;
          if (elapsed >= VeerHoldMs && !keep) begin
            mdl_mode = MODE_NONE;
            mdl_side = 0;
            r.lock = 1'b1;
            mdl_released = 1'b0;
          end
        end
      endcase
    end else if (f < cfg.front_stop) begin
      r.rel = 1'b1;
      mdl_released = 1'b1;
      mdl_side = (rt > l) ? 1 : -1;
      mdl_mode = MODE_PIVOT;
      mdl_start = t.now;
      v = 0;
      w = mdl_side * aw;
      r.code = oams_pkg::ASSIST_PIVOT;
      assisted = 1'b1;
    end else if (left_wall || right_wall) begin
      r.rel = 1'b1;
      mdl_released = 1'b1;
      mdl_side = left_wall ? 1 : -1;
      mdl_mode = MODE_VEER;
      mdl_start = t.now;
      v = sv;
      w = mdl_side * aw;
      r.code = oams_pkg::ASSIST_VEER;
      assisted = 1'b1;
    end else begin
      if (f < cfg.front_slow) begin
        if (v > sv) v = sv;
        r.code = oams_pkg::ASSIST_SLOW;
        assisted = 1'b1;
      end
      if (mdl_released) begin
        r.lock = 1'b1;
        mdl_released = 1'b0;
      end
    end

    if (assisted) begin
      ramp_spd += clamp_delta(v - ramp_spd, cfg.spd_step);
      ramp_yaw += clamp_delta(w - ramp_yaw, cfg.yaw_step);
      v = ramp_spd;
      w = ramp_yaw;
    end else begin
      ramp_spd = v;
      ramp_yaw = w;
    end
    r.spd = v[15:0];
    r.yaw = w[15:0];
    code_hits[r.code]++;
    if (r.lock) n_locks++;
    return r;
  endfunction

  function automatic logic [15:0] pick_mm(int lo, int hi);
    int unsigned x;
    x = $urandom_range(hi, lo);
    return x[15:0];
  endfunction

  function automatic logic [15:0] roll_range(int lo_thr, int hi_thr);
    int x;
    case ($urandom_range(9))
      0, 1: x = $urandom_range(65535);
      2, 3: x = lo_thr + $urandom_range(6) - 3;
      4, 5: x = hi_thr + $urandom_range(6) - 3;
      default: x = $urandom_range(2 * hi_thr + 64);
    endcase
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return x[15:0];
  endfunction

  function automatic logic signed [15:0] roll_s16();
    logic [31:0] rnd;
    rnd = $urandom;
    if (rnd[31:30] == 2'b00) return {{6{rnd[9]}}, rnd[9:0]};
    return rnd[15:0];
  endfunction

  function automatic tick_t tick_of(logic [31:0] now, logic [15:0] front, logic [15:0] left,
                                    logic [15:0] right, logic signed [15:0] spd,
                                    logic signed [15:0] yaw);
    tick_t t;
    t = {now, front, left, right, spd, yaw};
    return t;
  endfunction

  function automatic tick_t roll_tick(tick_kind_e kind);
    tick_t       t;
    logic [15:0] near_mm, far_mm;
    case ($urandom_range(49))
      0: t_ms = $urandom;
      1, 2, 3: t_ms += $urandom_range(2500);
      default: t_ms += $urandom_range(250);
    endcase
    t.now = t_ms;
    t.spd = roll_s16();
    t.yaw = roll_s16();
    t.front = roll_range(cfg.front_stop, cfg.front_slow);
    t.left = roll_range(cfg.side_block, cfg.side_clear);
    t.right = roll_range(cfg.side_block, cfg.side_clear);
    case (kind)
      TK_PIVOT: if (cfg.front_stop != 0) t.front = pick_mm(0, cfg.front_stop - 1);
      TK_WALL_L, TK_WALL_R: begin
        t.front = pick_mm(cfg.front_stop, 65535);
        if (cfg.side_block != 0 && cfg.side_clear != 16'hFFFF) begin
          near_mm = pick_mm(0, cfg.side_block - 1);
          far_mm = pick_mm(cfg.side_clear + 1, 65535);
          if (kind == TK_WALL_L) begin
            t.left = near_mm;
            t.right = far_mm;
          end else begin
            t.left = far_mm;
            t.right = near_mm;
          end
        end
      end
      TK_NOISE: begin
        t.now = $urandom;
        t_ms = t.now;
        t.front = pick_mm(0, 65535);
        t.left = pick_mm(0, 65535);
        t.right = pick_mm(0, 65535);
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic flag_mismatch(string msg);
    n_err++;
    if (n_err <= MaxPrinted) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_tick(tick_t t);
    bit taken;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    now_ms      <= t.now;
    front_range <= t.front;
    left_range  <= t.left;
    right_range <= t.right;
    speed_in    <= t.spd;
    yaw_rate_in <= t.yaw;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready_o;
      @(posedge clk);
    end while (!taken);
    shaped_q.push_back(shape_tick(t));
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (shaped_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic put_reg(oams_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_set_t c);
    put_reg(oams_pkg::CFG_FRONT_STOP, c.front_stop);
    put_reg(oams_pkg::CFG_FRONT_SLOW, c.front_slow);
    put_reg(oams_pkg::CFG_SIDE_BLOCK, c.side_block);
    put_reg(oams_pkg::CFG_SIDE_CLEAR, c.side_clear);
    put_reg(oams_pkg::CFG_SLOW_SPEED, {1'b0, c.slow_speed});
    put_reg(oams_pkg::CFG_ASSIST_YAW, {1'b0, c.assist_yaw});
    put_reg(oams_pkg::CFG_RAMP_SPEED, {1'b0, c.spd_step});
    put_reg(oams_pkg::CFG_RAMP_YAW, {1'b0, c.yaw_step});
    cfg_we <= 1'b0;
    cfg = c;
    n_cfg_loads++;
  endtask

  function automatic cfg_set_t roll_cfg(bit full);
    cfg_set_t    c;
    logic [15:0] r;
    if (full) begin
      c.front_stop = pick_mm(0, 65535);
      c.front_slow = pick_mm(0, 65535);
      c.side_block = pick_mm(0, 65535);
      c.side_clear = pick_mm(0, 65535);
      r = pick_mm(0, 32767); c.slow_speed = r[14:0];
      r = pick_mm(0, 32767); c.assist_yaw = r[14:0];
      r = pick_mm(0, 32767); c.spd_step = r[14:0];
      r = pick_mm(0, 32767); c.yaw_step = r[14:0];
    end else begin
      c.front_stop = pick_mm(0, 1500);
      c.front_slow = pick_mm(c.front_stop, c.front_stop + 1500);
      c.side_block = pick_mm(0, 800);
      c.side_clear = pick_mm(c.side_block, c.side_block + 800);
      r = pick_mm(0, 600);  c.slow_speed = r[14:0];
      r = pick_mm(0, 3000); c.assist_yaw = r[14:0];
      r = pick_mm(1, 400);  c.spd_step = r[14:0];
      r = pick_mm(1, 400);  c.yaw_step = r[14:0];
    end
    return c;
  endfunction

  // episodes: mostly well-formed obstacle encounters with random content
  task automatic run_episodes(int n_items);
    int         goal, len;
    tick_kind_e lead, body;
    goal = n_sent + n_items;
    while (n_sent < goal) begin
      len = $urandom_range(3, 32);
      case ($urandom_range(9))
        0, 1, 2, 3: begin lead = TK_PIVOT; body = TK_NEAR; end
        4: begin lead = TK_WALL_L; body = TK_WALL_L; end
        5: begin lead = TK_WALL_R; body = TK_WALL_R; end
        6, 7: begin lead = TK_NEAR; body = TK_NEAR; end
        8: begin lead = TK_NOISE; body = TK_NOISE; len = $urandom_range(1, 6); end
        default: begin
          settle();
          lead = TK_PIVOT;
          body = TK_NEAR;
        end
      endcase
      send_tick(roll_tick(lead));
      repeat (len - 1) send_tick(roll_tick(($urandom_range(9) < 7) ? body : TK_NEAR));
    end
  endtask

  task automatic test_directed();
    send_tick(tick_of(32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, -16'sh8000));
    send_tick(tick_of(32'd10, 16'd1000, 16'd600, 16'd600, -16'sh8000, 16'sh7FFF));
    // front exactly at the stop distance: slowing, not pivot
    send_tick(tick_of(32'd20, 16'd300, 16'd600, 16'd600, 16'sd1000, 16'sd50));
    send_tick(tick_of(32'd30, 16'd799, 16'd600, 16'd600, -16'sd500, -16'sd50));
    send_tick(tick_of(32'd40, 16'd800, 16'd600, 16'd600, 16'sd400, 16'sd0));
    // pivot right, leave on open front, bypass cut short by a close front
    send_tick(tick_of(32'd100, 16'd299, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd500, 16'd299, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd600, 16'd801, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd700, 16'd1000, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd800, 16'd100, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd1200, 16'd1000, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd1800, 16'd1000, 16'd400, 16'd401, 16'sd400, 16'sd0));
    send_tick(tick_of(32'd1810, 16'd1000, 16'd600, 16'd600, 16'sd200, 16'sd10));
    // equal sides pivot left; every stage ends on its timer
    send_tick(tick_of(32'd2000, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd0));
    send_tick(tick_of(32'd2800, 16'd500, 16'd0, 16'd0, 16'sd0, 16'sd0));
    send_tick(tick_of(32'd4300, 16'd500, 16'd0, 16'd0, 16'sd0, 16'sd0));
    send_tick(tick_of(32'd5300, 16'd500, 16'd0, 16'd0, 16'sd0, 16'sd0));
    // left wall veer, held past the minimum, released when the wall ties
    send_tick(tick_of(32'd6000, 16'hFFFF, 16'd249, 16'd501, 16'sd300, 16'sd0));
    send_tick(tick_of(32'd6499, 16'hFFFF, 16'd0, 16'hFFFF, 16'sd300, 16'sd0));
    send_tick(tick_of(32'd6500, 16'hFFFF, 16'd249, 16'd501, 16'sd300, 16'sd0));
    send_tick(tick_of(32'd6600, 16'hFFFF, 16'd250, 16'd501, 16'sd300, 16'sd0));
    // right wall veer across the time stamp wrap
    send_tick(tick_of(32'hFFFF_FF00, 16'hFFFF, 16'd600, 16'd0, 16'sd300, 16'sd0));
    send_tick(tick_of(32'h0000_0100, 16'hFFFF, 16'd600, 16'd300, 16'sd300, 16'sd0));
    t_ms = 32'h0000_0100;
  endtask

  task automatic test_avoid_episodes();
    run_episodes(450);
    // sender holds off until the pipeline is empty, then crosses the wrap
    settle();
    t_ms = 32'hFFFF_F800;
    run_episodes(450);
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    run_episodes(200);
    no_idle = 1'b0;
  endtask

  task automatic test_register_sweep();
    cfg_set_t c;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: c = '0;
        1: c = '1;
        2: c = roll_cfg(1'b0);
        3: c = roll_cfg(1'b1);
        4: begin
          c = roll_cfg(1'b0);
          c.spd_step = '0;
          c.yaw_step = '1;
        end
        5: begin
          c = roll_cfg(1'b0);
          c.assist_yaw = '1;
          c.spd_step = '1;
          c.yaw_step = '0;
        end
        default: c = DefaultCfg;
      endcase
      settle();
      load_config(c);
      run_episodes(80);
    end
  endtask

  initial begin : result_check
    shaped_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= IdlePct);
      @(negedge clk);
      if (rst_n && out_valid_o && out_ready) begin
        n_checked++;
        if (shaped_q.size() == 0) begin
          flag_mismatch("result arrived with no item outstanding");
        end else begin
          want = shaped_q.pop_front();
          if (speed_out_o !== want.spd)
            flag_mismatch($sformatf("item %0d speed_out %0d, expected %0d",
                                    n_checked, speed_out_o, want.spd));
          if (yaw_rate_out_o !== want.yaw)
            flag_mismatch($sformatf("item %0d yaw_rate_out %0d, expected %0d",
                                    n_checked, yaw_rate_out_o, want.yaw));
          if (assist_code_o !== want.code)
            flag_mismatch($sformatf("item %0d assist_code %0d, expected %0d",
                                    n_checked, assist_code_o, want.code));
          if (hold_release_o !== want.rel)
            flag_mismatch($sformatf("item %0d hold_release %b, expected %b",
                                    n_checked, hold_release_o, want.rel));
          if (hold_lock_o !== want.lock)
            flag_mismatch($sformatf("item %0d hold_lock %b, expected %b",
                                    n_checked, hold_lock_o, want.lock));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet, shaped_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = oams_pkg::CFG_FRONT_STOP;
    cfg_data     = '0;
    in_valid     = 1'b0;
    now_ms       = '0;
    front_range  = '0;
    left_range   = '0;
    right_range  = '0;
    speed_in     = '0;
    yaw_rate_in  = '0;
    no_idle      = 1'b0;
    t_ms         = '0;
    cfg          = DefaultCfg;
    mdl_mode     = MODE_NONE;
    mdl_side     = 0;
    mdl_start    = '0;
    mdl_released = 1'b0;
    ramp_spd     = NominalSpd;
    ramp_yaw     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_avoid_episodes();
    test_steady_stream();
    test_register_sweep();

    settle();
    $display("Checked %0d of %0d ticks across %0d register loads plus reset defaults.",
             n_checked, n_sent, n_cfg_loads);
    $display("Assist codes: none %0d slow %0d pivot %0d bypass %0d recover %0d veer %0d;",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5]);
    $display("Heading locks: %0d", n_locks);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
